// ===== sv/selective_repeat_receiver_defines.svh =====
// Assertion macros for the selective-repeat receiver.
// Used by the top level only; needs no other file.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SRR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define SRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/srr_pkg.sv =====
// Shared constants, result codes and control structs of the receiver.
// No dependencies; every other file but the assertion-macro header imports it.
package srr_pkg;

  localparam int WINDOW_SLOTS = 8;
  localparam int SEQ_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_BITS    = $clog2(WINDOW_SLOTS);

  localparam logic [SEQ_BITS-1:0] SLOTS_SEQ = SEQ_BITS'(WINDOW_SLOTS);

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [SLOT_BITS-1:0]    slot_idx_t;
  typedef logic [1:0]              kind_t;

  localparam kind_t KIND_DELIVER = 2'd0;
  localparam kind_t KIND_ACK     = 2'd1;
  localparam kind_t KIND_DISCARD = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_frame;
    logic write_slot;
    logic emit_deliver;
    logic emit_ack;
    logic emit_discard;
  } srr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic in_window;
    logic is_behind;
    logic head_filled;
    logic out_free;
  } srr_status_t;

endpackage

// ===== sv/srr_frame_if.sv =====
// Input channel carrying one arriving frame per transaction.
// Depends on srr_pkg.
interface srr_frame_if
  import srr_pkg::*;
();
  logic     valid;
  logic     ready;
  seq_t     frame_seq;
  payload_t frame_payload;

  modport source (output valid, output frame_seq, output frame_payload, input ready);
  modport sink   (input valid, input frame_seq, input frame_payload, output ready);
endinterface

// ===== sv/srr_result_if.sv =====
// Output channel carrying one result per transaction.
// Depends on srr_pkg.
interface srr_result_if
  import srr_pkg::*;
();
  logic     valid;
  logic     ready;
  kind_t    result_kind;
  seq_t     result_seq;
  payload_t result_payload;
  logic     result_last;

  modport source (output valid, output result_kind, output result_seq,
                  output result_payload, output result_last, input ready);
  modport sink   (input valid, input result_kind, input result_seq,
                  input result_payload, input result_last, output ready);
endinterface

// ===== sv/srr_ctrl.sv =====
// Sequencing state machine of the receiver: accept, classify, drain.
// Depends on srr_pkg; drives commands into srr_datapath.
module srr_ctrl
  import srr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  output logic        frame_ready,
  input  srr_status_t stat,
  output srr_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_CLASSIFY = 2'd1;
  localparam logic [1:0] ST_DRAIN    = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    frame_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        frame_ready = 1'b1;
        if (frame_valid) begin
          cmd.load_frame = 1'b1;
          state_next     = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        priority if (stat.in_window) begin
          cmd.write_slot = 1'b1;
          state_next     = ST_DRAIN;
        end else if (stat.out_free) begin
          cmd.emit_ack     = stat.is_behind;
          cmd.emit_discard = !stat.is_behind;
          state_next       = ST_IDLE;
        end else begin
          // Hold until the result register frees.
          state_next = ST_CLASSIFY;
        end
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          if (stat.head_filled) begin
            cmd.emit_deliver = 1'b1;
          end else begin
            cmd.emit_ack = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/srr_datapath.sv =====
// Window base, slot store with filled marks, and the result register.
// Depends on srr_pkg; commanded by srr_ctrl.
module srr_datapath
  import srr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  srr_cmd_t    cmd,
  output srr_status_t stat,
  input  seq_t        frame_seq,
  input  payload_t    frame_payload,
  input  logic        result_ready,
  output logic        result_valid,
  output kind_t       result_kind,
  output seq_t        result_seq,
  output payload_t    result_payload,
  output logic        result_last
);

  seq_t                      base;
  logic [WINDOW_SLOTS-1:0]   filled;
  payload_t                  slot_store [WINDOW_SLOTS];
  seq_t                      cur_seq;
  payload_t                  cur_payload;

  seq_t      ahead;
  seq_t      behind;
  slot_idx_t frame_slot;
  slot_idx_t base_slot;
  logic      emit_any;

  assign ahead      = cur_seq - base;
  assign behind     = base - cur_seq;
  assign frame_slot = SLOT_BITS'(cur_seq % WINDOW_SLOTS);
  assign base_slot  = SLOT_BITS'(base % WINDOW_SLOTS);
  assign emit_any   = cmd.emit_deliver || cmd.emit_ack || cmd.emit_discard;

  assign stat.in_window   = (ahead < SLOTS_SEQ);
  assign stat.is_behind   = (behind != '0) && (behind <= SLOTS_SEQ);
  assign stat.head_filled = filled[base_slot];
  assign stat.out_free    = !result_valid || result_ready;

  // Hold the frame under work.
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      cur_seq     <= frame_seq;
      cur_payload <= frame_payload;
    end
  end

  // Slot payloads need no reset: a slot is only read once marked.
  always_ff @(posedge clk) begin
    if (cmd.write_slot) begin
      slot_store[frame_slot] <= cur_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      filled <= '0;
    end else begin
      if (cmd.write_slot) begin
        filled[frame_slot] <= 1'b1;
      end
      if (cmd.emit_deliver) begin
        filled[base_slot] <= 1'b0;
        base              <= base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_any) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_deliver) begin
      result_kind    <= KIND_DELIVER;
      result_seq     <= base;
      result_payload <= slot_store[base_slot];
      result_last    <= 1'b0;
    end else if (cmd.emit_ack || cmd.emit_discard) begin
      result_kind    <= cmd.emit_ack ? KIND_ACK : KIND_DISCARD;
      result_seq     <= cur_seq;
      result_payload <= '0;
      result_last    <= 1'b1;
    end
  end

endmodule

// ===== sv/selective_repeat_receiver.sv =====
// Selective-repeat ARQ receiver. Each frame transaction on the frame channel
// carries a sequence number and a payload word. A number inside the window
// [base, base + WINDOW_SLOTS) modulo 2^SEQ_BITS has its payload stored in
// slot (number mod WINDOW_SLOTS); every consecutive filled slot from the base
// is then delivered in order (kind deliver, last low), and an acknowledgement
// of the frame's number closes the burst (last high). A number up to
// WINDOW_SLOTS below the base is acknowledged again with no change of state;
// any other number gives one discard result. One frame is handled at a time:
// the next frame is not accepted until the last result of the current one is
// loaded. The drain sequencer walks the base one slot per cycle into the
// single result register while that register is free; back-pressure on the
// result channel stalls it. No clearing pass is needed after reset.
// Depends on srr_pkg, srr_frame_if, srr_result_if, srr_ctrl, srr_datapath
// and selective_repeat_receiver_defines.svh.
`include "selective_repeat_receiver_defines.svh"

module selective_repeat_receiver
  import srr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  srr_frame_if.sink  frame,
  srr_result_if.source result
);

  srr_cmd_t    cmd;
  srr_status_t stat;

  // Controller: decide what the datapath does each cycle.
  srr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Datapath: window base, slot store and result register.
  srr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .frame_seq      (frame.frame_seq),
    .frame_payload  (frame.frame_payload),
    .result_ready   (result.ready),
    .result_valid   (result.valid),
    .result_kind    (result.result_kind),
    .result_seq     (result.result_seq),
    .result_payload (result.result_payload),
    .result_last    (result.result_last)
  );

  // Only one frame is in work: no accept straight after an accept.
  `SRR_ASSERT_NEXT(a_one_frame, clk, rst, frame.valid && frame.ready, !frame.ready, "frame accepted while busy")
  // A delivery shows up next cycle as a non-final deliver result.
  `SRR_ASSERT_NEXT(a_deliver_out, clk, rst, cmd.emit_deliver, result.valid && result.result_kind == KIND_DELIVER && !result.result_last, "delivery lost")
  // At most one result is loaded per cycle, and only into a free register.
  `SRR_ASSERT_IMPL(a_one_emit, clk, rst, cmd.emit_deliver || cmd.emit_ack || cmd.emit_discard, $onehot({cmd.emit_deliver, cmd.emit_ack, cmd.emit_discard}) && stat.out_free, "result register overrun")
  // A slot is written only for a frame inside the window.
  `SRR_ASSERT_IMPL(a_write_in_window, clk, rst, cmd.write_slot, stat.in_window && !cmd.load_frame, "slot written outside window")

endmodule
